// ----- hdl/tpsd_pkg.sv -----
package tpsd_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

  // index of the last palette byte, at which loading ends, for 4 and 3 byte entries
  localparam logic [9:0] PAL_END4 = 10'(PALETTE_ENTRIES * 4 - 1);
  localparam logic [9:0] PAL_END3 = 10'(PALETTE_ENTRIES * 3 - 1);

  localparam logic [1:0] KIND_CMAP = 2'd0;
  localparam logic [1:0] KIND_TRUE = 2'd1;

  localparam logic [2:0] REG_IMAGE_KIND        = 3'd0;
  localparam logic [2:0] REG_RLE_COMPRESSED    = 3'd1;
  localparam logic [2:0] REG_PIXEL_HAS_ALPHA   = 3'd2;
  localparam logic [2:0] REG_PALETTE_HAS_ALPHA = 3'd3;
  localparam logic [2:0] REG_IMAGE_WIDTH       = 3'd4;
  localparam logic [2:0] REG_IMAGE_HEIGHT      = 3'd5;
  localparam logic [2:0] REG_TOP_DOWN          = 3'd6;

  localparam logic [7:0] RUN_FLAG     = 8'h80;
  localparam logic [7:0] COUNT_MASK   = 8'h7f;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  typedef enum logic [2:0] {
    PH_PALETTE = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PIXEL   = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0]  image_kind;
    logic        rle_compressed;
    logic        pixel_has_alpha;
    logic        palette_has_alpha;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        top_down;
  } cfg_t;

  // one decoded step handed from the byte decoder to the placement stage
  typedef struct packed {
    logic        start;
    logic        zero_dims;
    logic        emit;
    logic        use_palette;
    logic [31:0] rgba;
    logic [7:0]  copies;
  } item_t;

  typedef struct packed {
    logic settling;
    logic wrapping;
  } place_status_t;

  // floor(n / 3) for a 10-bit count, by reciprocal multiply
  function automatic logic [8:0] div3(input logic [9:0] n);
    logic [19:0] p;
    p = 20'(n) * 20'd683;
    return p[19:11];
  endfunction

endpackage

// ----- hdl/tpsd_front.sv -----
module tpsd_front (
  input  logic            clk,
  input  logic            rst,
  input  tpsd_pkg::cfg_t  cfg,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            start_of_image,
  input  logic            take,
  output logic            item_valid,
  output tpsd_pkg::item_t item,
  output logic [31:0]     pal_rgba
);
  import tpsd_pkg::*;

  logic [31:0] pal_mem [PALETTE_ENTRIES];

  phase_t      phase, phase_next;
  logic [9:0]  pal_cnt, pal_cnt_next;
  logic [1:0]  pix_idx, pix_idx_next;
  logic [23:0] assembly, assembly_next;
  logic [7:0]  pkt_rem, pkt_rem_next;
  logic        pkt_run, pkt_run_next;
  logic        img_void, img_void_next;

  logic        zero_dims;
  phase_t      e_phase;
  logic [9:0]  e_cnt;
  logic [1:0]  e_idx;
  logic [23:0] e_asm;
  logic [7:0]  e_rem;
  logic        e_run;
  logic        e_void;

  logic              bpe4;
  logic [8:0]        q3;
  logic [9:0]        r3;
  logic [1:0]        pal_pos;
  logic [PAL_AW-1:0] pal_entry;
  logic              pal_last_byte;
  logic              pal_end;
  logic              is_pal;
  logic              is_header;
  logic [2:0]        bpp;
  logic [1:0]        sel;
  logic              clear;
  logic [31:0]       af;
  logic [2:0]        idx_inc;
  logic              pix_done;
  logic [31:0]       rgba_direct;
  logic              wr_en;
  logic              rd_en;
  logic              emit;
  logic [7:0]        copies;
  logic              push;

  assign zero_dims = (cfg.image_width == 16'd0) || (cfg.image_height == 16'd0);

  // start of image clears progress before this beat is decoded
  always_comb begin
    if (start_of_image) begin
      if (cfg.image_kind == KIND_CMAP) e_phase = PH_PALETTE;
      else if (cfg.rle_compressed)     e_phase = PH_HEADER;
      else                             e_phase = PH_PIXEL;
    end else begin
      e_phase = phase;
    end
  end

  assign e_cnt  = start_of_image ? 10'd0 : pal_cnt;
  assign e_idx  = start_of_image ? 2'd0 : pix_idx;
  assign e_asm  = start_of_image ? 24'd0 : assembly;
  assign e_rem  = start_of_image ? 8'd0 : pkt_rem;
  assign e_run  = start_of_image ? 1'b0 : pkt_run;
  assign e_void = start_of_image ? zero_dims : img_void;

  assign bpe4      = cfg.palette_has_alpha;
  assign q3        = div3(e_cnt);
  assign r3        = e_cnt - (10'(q3) + {q3, 1'b0});
  assign pal_pos   = bpe4 ? e_cnt[1:0] : r3[1:0];
  assign pal_entry = bpe4 ? e_cnt[PAL_AW+1:2] : q3[PAL_AW-1:0];
  assign pal_last_byte = (pal_pos == (bpe4 ? 2'd3 : 2'd2));
  assign pal_end   = bpe4 ? (e_cnt >= PAL_END4) : (e_cnt >= PAL_END3);

  assign is_pal    = (e_phase == PH_PALETTE);
  assign is_header = (e_phase == PH_HEADER) && cfg.rle_compressed;

  assign bpp = (cfg.image_kind == KIND_TRUE) ? (cfg.pixel_has_alpha ? 3'd4 : 3'd3) : 3'd1;

  assign sel   = is_pal ? pal_pos : e_idx;
  assign clear = is_pal ? (pal_pos == 2'd0) : (e_idx == 2'd0);
  assign af    = {8'd0, (clear ? 24'd0 : e_asm)} | (32'(data_byte) << {sel, 3'b000});

  assign idx_inc  = {1'b0, e_idx} + 3'd1;
  assign pix_done = (idx_inc >= bpp);

  always_comb begin
    if (cfg.image_kind == KIND_TRUE) begin
      rgba_direct = {af[23:16], af[15:8], af[7:0],
                     (cfg.pixel_has_alpha ? af[31:24] : ALPHA_OPAQUE)};
    end else begin
      rgba_direct = {af[7:0], af[7:0], af[7:0], ALPHA_OPAQUE};
    end
  end

  always_comb begin
    phase_next    = phase;
    pal_cnt_next  = pal_cnt;
    pix_idx_next  = pix_idx;
    assembly_next = assembly;
    pkt_rem_next  = pkt_rem;
    pkt_run_next  = pkt_run;
    img_void_next = img_void;
    wr_en  = 1'b0;
    rd_en  = 1'b0;
    emit   = 1'b0;
    copies = 8'd1;
    if (accept) begin
      phase_next    = e_phase;
      pal_cnt_next  = e_cnt;
      pix_idx_next  = e_idx;
      assembly_next = e_asm;
      pkt_rem_next  = e_rem;
      pkt_run_next  = e_run;
      img_void_next = e_void;
      if (!e_void) begin
        if (is_pal) begin
          assembly_next = af[23:0];
          if (pal_last_byte) begin
            wr_en = 1'b1;
            assembly_next = 24'd0;
          end
          if (pal_end) begin
            pal_cnt_next = 10'd0;
            phase_next   = cfg.rle_compressed ? PH_HEADER : PH_PIXEL;
          end else begin
            pal_cnt_next = e_cnt + 10'd1;
          end
        end else if (is_header) begin
          pkt_run_next  = ((data_byte & RUN_FLAG) != 8'd0);
          pkt_rem_next  = (data_byte & COUNT_MASK) + 8'd1;
          pix_idx_next  = 2'd0;
          assembly_next = 24'd0;
          phase_next    = PH_PIXEL;
        end else begin
          assembly_next = af[23:0];
          if (!pix_done) begin
            pix_idx_next = idx_inc[1:0];
          end else begin
            pix_idx_next = 2'd0;
            emit  = 1'b1;
            rd_en = (cfg.image_kind == KIND_CMAP);
            if (cfg.rle_compressed) begin
              if (e_run) copies = (e_rem != 8'd0) ? e_rem : 8'd1;
              if (e_run || e_rem <= 8'd1) begin
                pkt_rem_next = 8'd0;
                phase_next   = PH_HEADER;
              end else begin
                pkt_rem_next = e_rem - 8'd1;
              end
            end else begin
              phase_next = PH_PIXEL;
            end
          end
        end
      end
    end
  end

  assign push = accept && (start_of_image || emit);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_PIXEL;
      pal_cnt  <= 10'd0;
      pix_idx  <= 2'd0;
      assembly <= 24'd0;
      pkt_rem  <= 8'd0;
      pkt_run  <= 1'b0;
      img_void <= 1'b0;
      item_valid <= 1'b0;
    end else begin
      phase    <= phase_next;
      pal_cnt  <= pal_cnt_next;
      pix_idx  <= pix_idx_next;
      assembly <= assembly_next;
      pkt_rem  <= pkt_rem_next;
      pkt_run  <= pkt_run_next;
      img_void <= img_void_next;
      if (push)      item_valid <= 1'b1;
      else if (take) item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      item.start       <= start_of_image;
      item.zero_dims   <= zero_dims;
      item.emit        <= emit;
      item.use_palette <= (cfg.image_kind == KIND_CMAP);
      item.rgba        <= rgba_direct;
      item.copies      <= copies;
    end
  end

  // palette: written during load, read when an index completes
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pal_mem[pal_entry] <= {af[23:16], af[15:8], af[7:0],
                             (bpe4 ? af[31:24] : ALPHA_OPAQUE)};
    end
    if (rd_en) begin
      pal_rgba <= pal_mem[af[PAL_AW-1:0]];
    end
  end

endmodule

// ----- hdl/tpsd_place.sv -----
module tpsd_place (
  input  logic                    clk,
  input  logic                    rst,
  input  tpsd_pkg::cfg_t          cfg,
  input  logic                    cfg_write,
  input  logic                    item_valid,
  input  tpsd_pkg::item_t         item,
  input  logic [31:0]             pal_rgba,
  output logic                    take,
  output tpsd_pkg::place_status_t status,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              red,
  output logic [7:0]              green,
  output logic [7:0]              blue,
  output logic [7:0]              alpha,
  output logic [15:0]             dest_row,
  output logic [15:0]             dest_col,
  output logic [7:0]              repeat_count,
  output logic                    last_of_image
);
  import tpsd_pkg::*;

  logic [15:0] row;
  logic [16:0] col;
  logic [31:0] rem;
  logic        done;
  logic        wrapping;
  logic [31:0] total;
  logic [31:0] span;
  logic [1:0]  settle;

  logic [15:0] e_row;
  logic [16:0] e_col;
  logic [31:0] e_rem;
  logic        e_done;
  logic [16:0] width17;
  logic        in_range;
  logic        fire;
  logic        drop;
  logic        last;
  logic [7:0]  rpt;
  logic [31:0] rgba;
  logic [16:0] sum;
  logic [16:0] wsum;
  logic [16:0] col_less_w;

  assign width17 = {1'b0, cfg.image_width};

  assign e_row  = item.start ? 16'd0 : row;
  assign e_col  = item.start ? 17'd0 : col;
  assign e_rem  = item.start ? total : rem;
  assign e_done = item.start ? item.zero_dims : done;

  assign take = item_valid && !wrapping && (!out_valid || out_ready);

  assign in_range = (cfg.image_width != 16'd0) && (e_row < cfg.image_height) &&
                    (e_col < width17);
  assign fire = take && item.emit && !e_done && in_range;
  assign drop = take && item.emit && !e_done && !in_range;

  // rem is the pixel count from the current position to the image end
  assign last = (e_rem <= 32'(item.copies));
  assign rpt  = last ? e_rem[7:0] : item.copies;
  assign rgba = item.use_palette ? pal_rgba : item.rgba;

  assign sum        = e_col + 17'(rpt);
  assign wsum       = sum - width17;
  assign col_less_w = col - width17;

  assign status.settling = (settle != 2'd0);
  assign status.wrapping = wrapping;

  // image size products, refreshed every cycle
  always_ff @(posedge clk) begin
    total <= 32'(cfg.image_width) * 32'(cfg.image_height);
    span  <= 32'(cfg.image_height - row) * 32'(cfg.image_width);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row      <= 16'd0;
      col      <= 17'd0;
      rem      <= 32'd0;
      done     <= 1'b0;
      wrapping <= 1'b0;
      settle   <= 2'd0;
    end else begin
      if (cfg_write)            settle <= 2'd2;
      else if (settle != 2'd0)  settle <= settle - 2'd1;
      // new size mid image: rebuild the remaining count from row and column
      if (settle == 2'd1) rem <= span - 32'(col);

      if (wrapping) begin
        col      <= col_less_w;
        row      <= row + 16'd1;
        wrapping <= (col_less_w >= width17);
      end else if (take) begin
        row  <= e_row;
        col  <= e_col;
        rem  <= e_rem;
        done <= e_done | drop;
        if (fire) begin
          if (last) begin
            done <= 1'b1;
            row  <= cfg.image_height;
            col  <= 17'd0;
            rem  <= 32'd0;
          end else begin
            rem <= e_rem - 32'(rpt);
            if (sum < width17) begin
              col <= sum;
            end else begin
              // more rows to cross are stepped one per cycle
              col      <= wsum;
              row      <= e_row + 16'd1;
              wrapping <= (wsum >= width17);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      red           <= rgba[31:24];
      green         <= rgba[23:16];
      blue          <= rgba[15:8];
      alpha         <= rgba[7:0];
      dest_row      <= cfg.top_down ? e_row : (cfg.image_height - 16'd1 - e_row);
      dest_col      <= e_col[15:0];
      repeat_count  <= rpt;
      last_of_image <= last;
    end
  end

endmodule

// ----- hdl/tga_pixel_stream_decoder.sv -----
// channel | direction | handshake            | payload
// in      | input     | in_valid, in_ready   | data_byte, start_of_image
// out     | output    | out_valid, out_ready | red, green, blue, alpha, dest_row,
//         |           |                      | dest_col, repeat_count, last_of_image
// cfg     | input     | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// one byte per cycle while in_ready is high; a pixel is registered as a decoded item
// (its palette read registered alongside) and then into the output register
// a run that crosses more than one row boundary holds the placement stage while it
// steps across each further row (rows narrower than the run)
// after a config beat the input is held while the size products settle
// rst is synchronous; the palette is not cleared and reads as undefined until loaded
module tga_pixel_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        start_of_image,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic [15:0] dest_row,
  output logic [15:0] dest_col,
  output logic [7:0]  repeat_count,
  output logic        last_of_image,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import tpsd_pkg::*;

  cfg_t          cfg;
  logic          cfg_write;
  logic          in_accept;
  logic          item_valid;
  item_t         item;
  logic [31:0]   pal_rgba;
  logic          take;
  place_status_t status;

  assign cfg_ready = !item_valid && !status.wrapping;
  assign cfg_write = cfg_valid && cfg_ready;
  assign in_ready  = !status.settling && !cfg_valid && (!item_valid || take);
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_kind        <= KIND_TRUE;
      cfg.rle_compressed    <= 1'b0;
      cfg.pixel_has_alpha   <= 1'b0;
      cfg.palette_has_alpha <= 1'b0;
      cfg.image_width       <= 16'd0;
      cfg.image_height      <= 16'd0;
      cfg.top_down          <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_KIND:        cfg.image_kind        <= cfg_data[1:0];
        REG_RLE_COMPRESSED:    cfg.rle_compressed    <= cfg_data[0];
        REG_PIXEL_HAS_ALPHA:   cfg.pixel_has_alpha   <= cfg_data[0];
        REG_PALETTE_HAS_ALPHA: cfg.palette_has_alpha <= cfg_data[0];
        REG_IMAGE_WIDTH:       cfg.image_width       <= cfg_data;
        REG_IMAGE_HEIGHT:      cfg.image_height      <= cfg_data;
        REG_TOP_DOWN:          cfg.top_down          <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tpsd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .accept         (in_accept),
    .data_byte      (data_byte),
    .start_of_image (start_of_image),
    .take           (take),
    .item_valid     (item_valid),
    .item           (item),
    .pal_rgba       (pal_rgba)
  );

  tpsd_place u_place (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cfg_write     (cfg_write),
    .item_valid    (item_valid),
    .item          (item),
    .pal_rgba      (pal_rgba),
    .take          (take),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .alpha         (alpha),
    .dest_row      (dest_row),
    .dest_col      (dest_col),
    .repeat_count  (repeat_count),
    .last_of_image (last_of_image)
  );

endmodule

// ----- hdl/tpsd_checker.sv -----
module tpsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  red,
  input logic [7:0]  green,
  input logic [7:0]  blue,
  input logic [7:0]  alpha,
  input logic [15:0] dest_row,
  input logic [15:0] dest_col,
  input logic [7:0]  repeat_count,
  input logic        last_of_image
);

  // a waiting beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(red) && $stable(green) && $stable(blue) &&
      $stable(alpha) && $stable(dest_row) && $stable(dest_col) &&
      $stable(repeat_count) && $stable(last_of_image))
    else $error("output payload changed while stalled");

  // every run covers at least one pixel and never more than a packet
  a_repeat_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> repeat_count != 8'd0 && repeat_count <= 8'd128)
    else $error("repeat count out of range");

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind tga_pixel_stream_decoder tpsd_checker u_tpsd_checker (.*);
